[design/compacting_list_store_core_defines.svh]
// Assertion macros used by the list store datapath.
`ifndef COMPACTING_LIST_STORE_CORE_DEFINES_SVH
`define COMPACTING_LIST_STORE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define CLSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define CLSC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CLSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLSC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[design/clsc_pkg.sv]
`default_nettype none

package clsc_pkg;

	localparam int CLSC_DEPTH     = 16;
	localparam int CLSC_WORD_BITS = 32;

	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int RDVAL_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_WRITE  = 2'd3
	} clsc_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} clsc_status_t;

	// Controller to datapath
	typedef struct packed {
		logic         capture;   // latch the accepted item
		logic         append;    // store word at count, bump count
		logic         wr_entry;  // overwrite entry at index
		logic         rd_issue;  // start a read at index
		logic         rd_take;   // keep the read word for the result
		logic         rm_begin;  // point the mover just past index
		logic         shift;     // read at mover, write the previous word down
		logic         drop;      // flush the last moved word, shrink count
		logic         set_res;   // start a fresh result
		clsc_status_t res_status;
		logic         load_out;  // move result into the output register
	} clsc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		clsc_kind_t kind;
		logic       full;
		logic       oob;
		logic       rm_short;  // nothing sits after the removed entry
		logic       last;      // mover points at the last entry
		logic       out_free;
	} clsc_sts_t;

endpackage

`default_nettype wire

[design/compacting_list_store_core.sv]
`default_nettype none

// Channel   Dir  Handshake          tdata (low bit up)                    tuser
// s_*       in   s_tvalid/s_tready  index[3:0], value[35:4], zero pad     kind[1:0]
// m_*       out  m_tvalid/m_tready  read_value[31:0], count[36:32], pad   status[1:0]
//
// One item is worked at a time; s_tready is high only while the controller idles.
// Append, write, rejects and a remove of the last entry go from decode to finish.
// Read adds a wait state for the registered read port of the entry RAM. Other removes
// add one move step per entry moved down (count - index - 1), then a drain step.
// arst_n clears the count, the controller and the output valid; entries are not cleared.
// A result waits in the output register; the controller stalls only if it is still full.

module compacting_list_store_core
	import clsc_pkg::*;
#(
	parameter int DEPTH     = CLSC_DEPTH,
	parameter int WORD_BITS = CLSC_WORD_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // index[3:0], value[35:4], zero pad
	input  wire logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [M_TDATA_W-1:0] m_tdata,   // read_value[31:0], count[36:32], zero pad
	output      logic [STATUS_W-1:0]  m_tuser    // status[1:0]
);

	// Command and status buses between the sequencer and the datapath
	clsc_cmd_t cmd;
	clsc_sts_t sts;

	// Sequence each transaction: decode, read, move entries, deliver
	clsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the list, the count, the mover and the output register
	clsc_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

[design/clsc_ram.sv]
`default_nettype none

module clsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/clsc_ctrl.sv]
`default_nettype none

module clsc_ctrl
	import clsc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output      logic      s_tready,
	input  wire clsc_sts_t sts,
	output      clsc_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXEC   = 6'b000010,
		ST_RDWAIT = 6'b000100,
		ST_SHIFT  = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.set_res = 1'b1;
				state_d     = ST_FINISH;
				if (sts.kind == KIND_APPEND) begin
					if (sts.full) begin
						cmd.res_status = STAT_FULL;
					end else begin
						cmd.res_status = STAT_DONE;
						cmd.append     = 1'b1;
					end
				end else if (sts.oob) begin
					cmd.res_status = STAT_RANGE;
				end else begin
					cmd.res_status = STAT_DONE;
					case (sts.kind)
						KIND_WRITE: begin
							cmd.wr_entry = 1'b1;
						end
						KIND_READ: begin
							cmd.rd_issue = 1'b1;
							state_d      = ST_RDWAIT;
						end
						KIND_REMOVE: begin
							if (sts.rm_short) begin
								cmd.drop = 1'b1;
							end else begin
								cmd.rm_begin = 1'b1;
								state_d      = ST_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RDWAIT: begin
				cmd.rd_take = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.drop = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[design/clsc_dp.sv]
`default_nettype none

`include "compacting_list_store_core_defines.svh"

module clsc_dp
	import clsc_pkg::*;
#(
	parameter int DEPTH     = CLSC_DEPTH,
	parameter int WORD_BITS = CLSC_WORD_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire clsc_cmd_t              cmd,
	output      clsc_sts_t              sts,
	input  wire logic [S_TDATA_W-1:0]   s_tdata,
	input  wire logic [KIND_W-1:0]      s_tuser,
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [M_TDATA_W-1:0]   m_tdata,
	output      logic [STATUS_W-1:0]    m_tuser
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W + 1 > COUNT_W) ? CNT_W + 1 : COUNT_W;
	localparam int VW    = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
	localparam int PAD_W = M_TDATA_W - RDVAL_W - COUNT_W;

	// Captured item
	clsc_kind_t           kind_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [WORD_BITS-1:0] word_q;

	// List state and mover
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [AW-1:0]        wr_addr_q;
	logic                 pend_q;

	// Result and output register
	logic [WORD_BITS-1:0] res_rd_q;
	clsc_status_t         res_status_q;
	logic                 m_valid_q;
	logic [RDVAL_W-1:0]   m_rd_q;
	logic [COUNT_W-1:0]   m_cnt_q;
	logic [STATUS_W-1:0]  m_st_q;

	logic [VW-1:0]        in_ext;
	logic [VW-1:0]        rd_ext;
	logic [CMP_W-1:0]     idx_x;
	logic [CMP_W-1:0]     cnt_x;
	logic [CMP_W-1:0]     ptr_x;
	logic [CNT_W-1:0]     ptr_m1;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	assign in_ext = VW'(s_tdata[INDEX_W +: VALUE_W]);
	assign idx_x  = CMP_W'(idx_q);
	assign cnt_x  = CMP_W'(count_q);
	assign ptr_x  = CMP_W'(ptr_q);
	assign ptr_m1 = ptr_q - CNT_W'(1);

	assign sts.kind     = kind_q;
	assign sts.full     = (count_q >= CNT_W'(DEPTH));
	assign sts.oob      = (idx_x >= cnt_x);
	assign sts.rm_short = ((idx_x + CMP_W'(1)) >= cnt_x);
	assign sts.last     = ((ptr_x + CMP_W'(1)) >= cnt_x);
	assign sts.out_free = !m_valid_q || m_tready;

	// Storage ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = ram_rdata;
		if (cmd.append) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = word_q;
		end else if (cmd.wr_entry) begin
			ram_we    = 1'b1;
			ram_waddr = idx_x[AW-1:0];
			ram_wdata = word_q;
		end else if (pend_q && (cmd.shift || cmd.drop)) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = cmd.rd_issue || cmd.shift;
	assign ram_raddr = cmd.rd_issue ? idx_x[AW-1:0] : ptr_q[AW-1:0];

	clsc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= clsc_kind_t'(s_tuser);
			idx_q  <= s_tdata[INDEX_W-1:0];
			word_q <= in_ext[WORD_BITS-1:0];
		end
		if (cmd.set_res) begin
			res_rd_q     <= '0;
			res_status_q <= cmd.res_status;
		end
		if (cmd.rd_take) begin
			res_rd_q <= ram_rdata;
		end
		if (cmd.shift) begin
			wr_addr_q <= ptr_m1[AW-1:0];
		end
		if (cmd.load_out) begin
			m_rd_q  <= rd_ext[RDVAL_W-1:0];
			m_cnt_q <= cnt_x[COUNT_W-1:0];
			m_st_q  <= res_status_q;
		end
	end

	assign rd_ext = VW'(res_rd_q);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.drop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.rm_begin) begin
				ptr_q <= CNT_W'(idx_x + CMP_W'(1));
			end else if (cmd.shift) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.shift) begin
				pend_q <= 1'b1;
			end else if (cmd.drop) begin
				pend_q <= 1'b0;
			end
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {PAD_W'(0), m_cnt_q, m_rd_q};
	assign m_tuser  = m_st_q;

	`CLSC_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH), "count above capacity")
	`CLSC_ASSERT(a_count_hold, clk, arst_n, !(cmd.append || cmd.drop) |=> $stable(count_q), "count moved without append or remove")
	`CLSC_NEVER(a_drop_empty, clk, arst_n, cmd.drop && (count_q == '0), "remove from an empty list")
	`CLSC_NEVER(a_shift_range, clk, arst_n, cmd.shift && (ptr_q >= count_q), "mover read beyond the last entry")
	`CLSC_ASSERT(a_pend_shift, clk, arst_n, pend_q |-> $past(cmd.shift) || $past(pend_q), "move pending without a preceding read")

endmodule

`default_nettype wire

[bench/compacting_list_store_core_tb.sv]
`timescale 1ns / 1ps

module compacting_list_store_core_tb;
	import clsc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // index[3:0], value[35:4], zero pad
	logic [KIND_W-1:0]    s_tuser;   // kind[1:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // read_value[31:0], count[36:32], zero pad
	logic [STATUS_W-1:0]  m_tuser;   // status[1:0]

	compacting_list_store_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	typedef struct {
		logic [RDVAL_W-1:0] rd;
		logic [COUNT_W-1:0] cnt;
		clsc_status_t       st;
	} list_result_t;

	// Shadow copy of the list: tracks entries and count per accepted request
	// and keeps the replies still owed by the block, oldest first.
	class list_result_tracker;
		logic [CLSC_WORD_BITS-1:0] words [CLSC_DEPTH];
		int                        held;
		int                        taken;
		int                        faults;
		list_result_t              awaited [$];

		function new();
			held = 0;
			taken = 0;
			faults = 0;
			foreach (words[i]) words[i] = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void log_request(clsc_kind_t k, logic [INDEX_W-1:0] idx,
				logic [VALUE_W-1:0] val);
			list_result_t r;
			int i;
			r.rd = '0;
			r.st = STAT_DONE;
			taken++;
			if (k == KIND_APPEND) begin
				if (held >= CLSC_DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					words[held] = val;
					held++;
				end
			end else if (int'(idx) >= held) begin
				r.st = STAT_RANGE;
			end else begin
				case (k)
					KIND_REMOVE: begin
						// close the gap: every later entry moves down one place
						for (i = int'(idx) + 1; i < held; i++)
							words[i-1] = words[i];
						held--;
					end
					KIND_READ: begin
						r.rd = words[idx];
					end
					default: begin
						words[idx] = val;
					end
				endcase
			end
			r.cnt = held[COUNT_W-1:0];
			awaited.push_back(r);
		endfunction

		function void check_reply(logic [RDVAL_W-1:0] rd, logic [COUNT_W-1:0] cnt,
				logic [STATUS_W-1:0] st);
			list_result_t want;
			if (awaited.size() == 0) begin
				faults++;
				$display("%0t: unexpected result, read_value %h count %0d status %0d",
					$time, rd, cnt, st);
				return;
			end
			want = awaited.pop_front();
			if (rd !== want.rd) begin
				faults++;
				$display("%0t: read_value expected %h actual %h", $time, want.rd, rd);
			end
			if (cnt !== want.cnt) begin
				faults++;
				$display("%0t: count expected %0d actual %0d", $time, want.cnt, cnt);
			end
			if (st !== want.st) begin
				faults++;
				$display("%0t: status expected %0d actual %0d", $time, want.st, st);
			end
		endfunction
	endclass

	list_result_tracker book = new();

	// 0 favors growth, 1 favors shrinking, 2 mixes; switched per burst
	int trend;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watch both channels; a transaction counts at an edge with valid and ready high.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				book.check_reply(m_tdata[RDVAL_W-1:0], m_tdata[RDVAL_W +: COUNT_W], m_tuser);
			if (s_tvalid && s_tready)
				book.log_request(clsc_kind_t'(s_tuser), s_tdata[INDEX_W-1:0],
					s_tdata[INDEX_W +: VALUE_W]);
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic send_request(input clsc_kind_t k, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {{(S_TDATA_W-INDEX_W-VALUE_W){1'b0}}, val, idx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_cycles(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop valid and hold off until every owed reply has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
	endtask

	task automatic pick_request(output clsc_kind_t k, output logic [INDEX_W-1:0] idx,
			output logic [VALUE_W-1:0] val);
		int roll;
		int n;
		int grow_pct;
		int shrink_pct;
		n = book.held;
		roll = $urandom_range(0, 99);
		case (trend)
			0: begin grow_pct = 55; shrink_pct = 15; end
			1: begin grow_pct = 20; shrink_pct = 45; end
			default: begin grow_pct = 35; shrink_pct = 25; end
		endcase
		if (roll < grow_pct)
			k = KIND_APPEND;
		else if (roll < grow_pct + shrink_pct)
			k = KIND_REMOVE;
		else if (roll % 2)
			k = KIND_READ;
		else
			k = KIND_WRITE;
		// mostly hit live entries, sometimes any position (out of range included)
		if (n > 0 && $urandom_range(0, 9) < 8)
			idx = INDEX_W'($urandom_range(0, n - 1));
		else
			idx = INDEX_W'($urandom_range(0, 15));
		case ($urandom_range(0, 7))
			0: val = '0;
			1: val = '1;
			default: val = $urandom;
		endcase
	endtask

	task automatic run_random(input int total);
		int sent;
		int burst;
		int gap;
		int j;
		bit drained;
		clsc_kind_t k;
		logic [INDEX_W-1:0] idx;
		logic [VALUE_W-1:0] val;
		sent = 0;
		drained = 1'b0;
		while (sent < total) begin
			trend = $urandom_range(0, 2);
			burst = $urandom_range(1, 40);
			for (j = 0; j < burst && sent < total; j++) begin
				pick_request(k, idx, val);
				send_request(k, idx, val);
				sent++;
			end
			if (!drained && sent >= total / 2) begin
				drained = 1'b1;
				drain_results();
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				if (gap > 0) idle_cycles(gap);
			end
		end
	endtask

	// Receiver: stretches of always-ready, random and fixed stall patterns,
	// plus one long hold so the output backs up and stalls the input side.
	initial begin : sink
		int mode;
		int span;
		int phase;
		bit held_off;
		m_tready = 1'b0;
		phase = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 120);
			repeat (span) begin
				@(posedge clk);
				phase++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (phase % 5) < 2;
				endcase
			end
			if (!held_off && book.taken >= 300) begin
				held_off = 1'b1;
				@(posedge clk);
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("FAIL compacting_list_store_core");
		$finish;
	end

	initial begin : source
		int i;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		trend    = 2;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty list: index-based requests are out of range
		send_request(KIND_REMOVE, 4'd0, 32'hFFFF_FFFF);
		send_request(KIND_READ, 4'd0, 32'h0);
		// fill to capacity; the index field is ignored on append
		for (i = 0; i < CLSC_DEPTH; i++) begin
			case (i)
				0: send_request(KIND_APPEND, 4'hF, 32'h0000_0000);
				1: send_request(KIND_APPEND, 4'h0, 32'hFFFF_FFFF);
				2: send_request(KIND_APPEND, 4'h5, 32'h5555_5555);
				3: send_request(KIND_APPEND, 4'hA, 32'hAAAA_AAAA);
				default: send_request(KIND_APPEND, i[INDEX_W-1:0], $urandom);
			endcase
		end
		send_request(KIND_APPEND, 4'd0, 32'h1234_5678);   // full: refused
		send_request(KIND_READ, 4'd15, 32'hFFFF_FFFF);
		send_request(KIND_WRITE, 4'd0, 32'hFFFF_FFFF);
		send_request(KIND_REMOVE, 4'd0, 32'h0);            // longest shift
		send_request(KIND_REMOVE, 4'd14, 32'h0);           // last entry, nothing moves
		send_request(KIND_READ, 4'd14, 32'h0);             // index equals count
		send_request(KIND_WRITE, 4'd15, 32'hDEAD_BEEF);
		send_request(KIND_REMOVE, 4'd15, 32'h0);
		drain_results();

		run_random(900);

		drain_results();
		repeat (64) @(posedge clk);
		if (book.faults == 0 && book.pending() == 0)
			$display("PASS compacting_list_store_core");
		else
			$display("FAIL compacting_list_store_core");
		$finish;
	end

endmodule
